>>> src/mcg_pkg.sv
// Shared types, codes and reset values for the multi-click gesture classifier.
// Used by mcg_core and multi_click_gesture_classifier; depends on nothing else.
package mcg_pkg;

    localparam int NOW_W    = 31;
    localparam int KEY_W    = 2;
    localparam int ACTION_W = 4;
    localparam int COUNT_W  = 4;
    localparam int WIN_W    = 20;
    localparam int SPAN_W   = 24;
    localparam int DIFF_W   = NOW_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

    // Key event codes; the unused codes act as no event.
    localparam logic [KEY_W-1:0] KEY_PRESS   = 2'd1;
    localparam logic [KEY_W-1:0] KEY_RELEASE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_NOTICE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERY_LONG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG        = 3'd4;

    localparam logic [WIN_W-1:0]  IDLE_WINDOW_RST = 20'd30000;
    localparam logic [WIN_W-1:0]  HOLD_NOTICE_RST = 20'd30000;
    localparam logic [WIN_W-1:0]  SETTLE_RST      = 20'h02711;
    localparam logic [SPAN_W-1:0] VERY_LONG_RST   = 24'h0249f1;
    localparam logic [SPAN_W-1:0] LONG_RST        = 24'h015f91;

    // Result action codes.
    localparam logic [ACTION_W-1:0] ACT_NONE         = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_HOLD_NOTICE  = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_SINGLE       = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_SINGLE_HOLD  = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_DOUBLE       = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_TRIPLE       = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_REBOOT       = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_ACTIVATE     = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_VERY_LONG    = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_LONG         = 4'd9;

    typedef struct packed {
        logic [WIN_W-1:0]  idle_window_ms;
        logic [WIN_W-1:0]  hold_notice_ms;
        logic [WIN_W-1:0]  settle_ms;
        logic [SPAN_W-1:0] very_long_press_ms;
        logic [SPAN_W-1:0] long_press_ms;
    } mcg_cfg_t;

    typedef struct packed {
        logic [NOW_W-1:0]   press_time;
        logic [NOW_W-1:0]   release_time;
        logic [COUNT_W-1:0] click_count;
        logic               hold_noted;
        logic               halted;
    } mcg_state_t;

    // Signed difference of two time stamps.
    function automatic logic signed [DIFF_W-1:0] time_diff(
        input logic [NOW_W-1:0] a,
        input logic [NOW_W-1:0] b
    );
        time_diff = $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

endpackage

>>> src/multi_click_gesture_classifier.sv
// Multi-click touch-key gesture classifier, top level.
// Instantiates mcg_core; depends on mcg_pkg.

// Each input transfer carries a millisecond time stamp, a key event and a gate
// flag, and yields exactly one result transfer with an action code and the
// stopped flag. The block takes one item per clock cycle unless the result side
// applies back pressure: an item is captured in the input register, is classified
// against the gesture state in a single pass, and its result waits in the output
// register until it is taken. Throughput is limited only by
// back pressure on the result side. Configuration writes take effect at once
// and belong between items while the block is idle. After a quadruple or
// five-plus burst the block stops and answers every further item with no
// action and the stopped flag set, until reset.
module multi_click_gesture_classifier (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [30:0] now_ms, [32:31] key_event, [39:33] zero
    input  logic [mcg_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] processing_allowed
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [3:0] action, [4] stopped, [7:5] zero
    output logic [mcg_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mcg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mcg_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mcg_pkg::*;

    mcg_cfg_t             cfg_reg;
    mcg_state_t           state_reg;
    mcg_state_t           state_next;
    logic                 in_valid_reg;
    logic [NOW_W-1:0]     now_reg;
    logic [KEY_W-1:0]     key_reg;
    logic                 allowed_reg;
    logic                 out_valid_reg;
    logic [ACTION_W-1:0]  action_reg;
    logic                 stopped_reg;
    logic [ACTION_W-1:0]  action_next;
    logic                 advance;
    logic                 in_xfer;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-ACTION_W-1){1'b0}}, stopped_reg, action_reg};

    mcg_core u_core (
        .cfg                (cfg_reg),
        .state              (state_reg),
        .now_ms             (now_reg),
        .key_event          (key_reg),
        .processing_allowed (allowed_reg),
        .state_next         (state_next),
        .action             (action_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_window_ms     <= IDLE_WINDOW_RST;
            cfg_reg.hold_notice_ms     <= HOLD_NOTICE_RST;
            cfg_reg.settle_ms          <= SETTLE_RST;
            cfg_reg.very_long_press_ms <= VERY_LONG_RST;
            cfg_reg.long_press_ms      <= LONG_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IDLE_WINDOW: cfg_reg.idle_window_ms     <= cfg_data[WIN_W-1:0];
                REG_HOLD_NOTICE: cfg_reg.hold_notice_ms     <= cfg_data[WIN_W-1:0];
                REG_SETTLE:      cfg_reg.settle_ms          <= cfg_data[WIN_W-1:0];
                REG_VERY_LONG:   cfg_reg.very_long_press_ms <= cfg_data[SPAN_W-1:0];
                REG_LONG:        cfg_reg.long_press_ms      <= cfg_data[SPAN_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            now_reg     <= s_tdata[NOW_W-1:0];
            key_reg     <= s_tdata[NOW_W+KEY_W-1:NOW_W];
            allowed_reg <= s_tuser;
        end
        if (advance)
        begin
            action_reg  <= action_next;
            stopped_reg <= state_next.halted;
        end
    end

endmodule

>>> src/mcg_core.sv
// Next-state and action logic for one gesture item.
// Depends on mcg_pkg.
module mcg_core (
    input  mcg_pkg::mcg_cfg_t                cfg,
    input  mcg_pkg::mcg_state_t              state,
    input  logic [mcg_pkg::NOW_W-1:0]        now_ms,
    input  logic [mcg_pkg::KEY_W-1:0]        key_event,
    input  logic                             processing_allowed,
    output mcg_pkg::mcg_state_t              state_next,
    output logic [mcg_pkg::ACTION_W-1:0]     action
);
    import mcg_pkg::*;

    mcg_state_t                st1;
    logic signed [DIFF_W-1:0]  idle_diff;
    logic signed [DIFF_W-1:0]  held_diff;
    logic signed [DIFF_W-1:0]  span;
    logic signed [DIFF_W-1:0]  since_release;
    logic                      restart;
    logic                      hold_hit;
    logic                      decide_hit;
    logic [ACTION_W-1:0]       decided;
    logic                      stop_now;

    assign idle_diff = time_diff(now_ms, state.press_time);
    assign restart   = idle_diff > $signed({{(DIFF_W-WIN_W){1'b0}}, cfg.idle_window_ms});

    // Apply the key event first; the checks below see the updated times.
    always_comb
    begin
        st1 = state;
        case (key_event)
            KEY_PRESS:
            begin
                if (restart)
                begin
                    st1.release_time = '0;
                    st1.click_count  = '0;
                end
                if (st1.click_count != COUNT_MAX)
                    st1.click_count = st1.click_count + 4'd1;
                st1.press_time = now_ms;
            end
            KEY_RELEASE:
                st1.release_time = now_ms;
            default:
                st1 = state;
        endcase
    end

    assign held_diff     = time_diff(now_ms, st1.press_time);
    assign span          = time_diff(st1.release_time, st1.press_time);
    assign since_release = time_diff(now_ms, st1.release_time);

    assign hold_hit = (st1.click_count == 4'd1) && !st1.hold_noted
                      && (st1.release_time == '0)
                      && (held_diff > $signed({{(DIFF_W-WIN_W){1'b0}}, cfg.hold_notice_ms}));
    assign decide_hit = (span > 0)
                      && (since_release >= $signed({{(DIFF_W-WIN_W){1'b0}}, cfg.settle_ms}));

    always_comb
    begin
        stop_now = 1'b0;
        if (span >= $signed({{(DIFF_W-SPAN_W){1'b0}}, cfg.very_long_press_ms}))
            decided = ACT_VERY_LONG;
        else if (span >= $signed({{(DIFF_W-SPAN_W){1'b0}}, cfg.long_press_ms}))
            decided = ACT_LONG;
        else
        begin
            case (st1.click_count)
                4'd1:    decided = st1.hold_noted ? ACT_SINGLE_HOLD : ACT_SINGLE;
                4'd2:    decided = ACT_DOUBLE;
                4'd3:    decided = ACT_TRIPLE;
                4'd4:
                begin
                    decided  = ACT_REBOOT;
                    stop_now = 1'b1;
                end
                default:
                begin
                    decided  = ACT_ACTIVATE;
                    stop_now = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state;
        action     = ACT_NONE;
        if (!state.halted && processing_allowed)
        begin
            state_next = st1;
            if (st1.click_count != '0)
            begin
                if (hold_hit)
                begin
                    state_next.hold_noted = 1'b1;
                    action                = ACT_HOLD_NOTICE;
                end
                else if (decide_hit)
                begin
                    action                 = decided;
                    state_next.click_count = '0;
                    state_next.hold_noted  = 1'b0;
                    state_next.halted      = stop_now;
                end
            end
        end
    end

endmodule

>>> tb/tb_multi_click_gesture_classifier.sv
`timescale 1ns / 1ps
// Self-checking testbench for multi_click_gesture_classifier: predicts the action
// and stopped flag of every input transfer and compares them with the result stream.
// Depends on mcg_pkg and the classifier RTL only.
module tb_multi_click_gesture_classifier;
    import mcg_pkg::*;

    localparam logic [KEY_W-1:0] KEY_IDLE  = 2'd0;
    localparam logic [KEY_W-1:0] KEY_SPARE = 2'd3;
    localparam longint NOW_MAX     = (64'd1 << NOW_W) - 1;
    localparam longint TIME_REBASE = NOW_MAX - 64'd268435456;
    localparam int     CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                stopped;
    } verdict_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    multi_click_gesture_classifier dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Predicted gesture state and window settings.
    mcg_state_t gest;
    mcg_cfg_t   win_cfg;
    verdict_t   verdicts[$];

    int     errors;
    int     cycles;
    int     results;
    int     live_items;
    int     ignored_items;
    int     diverted;
    int     settings_used;
    int     action_seen[10];
    int     burst_left;
    int     stall_mode;
    int     stall_left;
    int     stop_clicks;
    bit     stop_allowed;
    longint clock_ms;
    verdict_t head;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic verdict_t classify(inout mcg_state_t g, input mcg_cfg_t c,
                                          input logic [NOW_W-1:0] now,
                                          input logic [KEY_W-1:0] key, input logic gate);
        verdict_t v;
        longint   span;
        v.action = ACT_NONE;
        if (!g.halted && gate)
        begin
            if (key == KEY_PRESS)
            begin
                if (longint'(now) - longint'(g.press_time) > longint'(c.idle_window_ms))
                begin
                    g.release_time = '0;
                    g.click_count  = '0;
                end
                if (g.click_count != COUNT_MAX)
                    g.click_count = g.click_count + 1'b1;
                g.press_time = now;
            end
            else if (key == KEY_RELEASE)
                g.release_time = now;

            if (g.click_count != 0)
            begin
                if (g.click_count == 1 && !g.hold_noted && g.release_time == 0 &&
                    longint'(now) - longint'(g.press_time) > longint'(c.hold_notice_ms))
                begin
                    g.hold_noted = 1'b1;
                    v.action     = ACT_HOLD_NOTICE;
                end
                span = longint'(g.release_time) - longint'(g.press_time);
                if (v.action == ACT_NONE && span > 0 &&
                    longint'(now) - longint'(g.release_time) >= longint'(c.settle_ms))
                begin
                    if (span >= longint'(c.very_long_press_ms))
                        v.action = ACT_VERY_LONG;
                    else if (span >= longint'(c.long_press_ms))
                        v.action = ACT_LONG;
                    else if (g.click_count == 1)
                        v.action = g.hold_noted ? ACT_SINGLE_HOLD : ACT_SINGLE;
                    else if (g.click_count == 2)
                        v.action = ACT_DOUBLE;
                    else if (g.click_count == 3)
                        v.action = ACT_TRIPLE;
                    else if (g.click_count == 4)
                    begin
                        v.action = ACT_REBOOT;
                        g.halted = 1'b1;
                    end
                    else
                    begin
                        v.action = ACT_ACTIVATE;
                        g.halted = 1'b1;
                    end
                    g.click_count = '0;
                    g.hold_noted  = 1'b0;
                end
            end
        end
        v.stopped = g.halted;
        return v;
    endfunction

    function automatic longint near(input longint x);
        longint y;
        y = x + longint'($urandom_range(0, 2)) - 1;
        return (y < 0) ? 0 : y;
    endfunction

    task automatic report(input string what, input int expv, input int gotv);
        $display("mismatch at result %0d: %s expected %0d got %0d", results, what, expv, gotv);
        errors++;
    endtask

    // Checks each result transfer and drives the receiver's stall pattern.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("multi_click_gesture_classifier regression: fail");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdicts.size() == 0)
                report("unexpected result, action", -1, m_tdata[ACTION_W-1:0]);
            else
            begin
                head = verdicts.pop_front();
                if (m_tdata[ACTION_W-1:0] != head.action)
                    report("action", head.action, m_tdata[ACTION_W-1:0]);
                if (m_tdata[ACTION_W] != head.stopped)
                    report("stopped", head.stopped, m_tdata[ACTION_W]);
            end
            if (m_tdata[ACTION_W-1:0] <= ACT_LONG)
                action_seen[m_tdata[ACTION_W-1:0]]++;
            results++;
        end
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 200);
        end
        stall_left--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((cycles % 3) == 0);
        endcase
    end

    // Sends one item. Outside the stop test, an item that would stop the block
    // is replaced by a press late enough to open a fresh burst, or gated off if none fits.
    task automatic send_item(input logic [NOW_W-1:0] now, input logic [KEY_W-1:0] key,
                             input logic gate);
        mcg_state_t probe;
        verdict_t   v;
        longint     t;
        int         gap;
        if (!stop_allowed && gate)
        begin
            probe = gest;
            v = classify(probe, win_cfg, now, key, gate);
            if (probe.halted)
            begin
                t = longint'(gest.press_time) + longint'(win_cfg.idle_window_ms) + 1 +
                    longint'($urandom_range(0, 40));
                if (t <= NOW_MAX)
                begin
                    now = t[NOW_W-1:0];
                    key = KEY_PRESS;
                    if (t > clock_ms)
                        clock_ms = t;
                end
                else
                    gate = 1'b0;
                diverted++;
            end
        end
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 5);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - NOW_W - KEY_W){1'b0}}, key, now};
        s_tuser  <= gate;
        do @(posedge clk); while (!s_tready);
        if (gate && !gest.halted)
            live_items++;
        else
            ignored_items++;
        v = classify(gest, win_cfg, now, key, gate);
        verdicts.push_back(v);
    endtask

    // Sends an item at an absolute time, now and then behind an ignored one.
    task automatic emit(input longint t, input logic [KEY_W-1:0] key, input logic gate);
        if (t > NOW_MAX)
            t = NOW_MAX;
        if (t < 0)
            t = 0;
        clock_ms = t;
        if ($urandom_range(0, 24) == 0)
            send_item(NOW_W'($urandom() & NOW_MAX), KEY_W'($urandom_range(0, 3)), 1'b0);
        send_item(t[NOW_W-1:0], key, gate);
    endtask

    task automatic wait_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Holds the write channel valid; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_IDLE_WINDOW: win_cfg.idle_window_ms     = val[WIN_W-1:0];
            REG_HOLD_NOTICE: win_cfg.hold_notice_ms     = val[WIN_W-1:0];
            REG_SETTLE:      win_cfg.settle_ms          = val[WIN_W-1:0];
            REG_VERY_LONG:   win_cfg.very_long_press_ms = val[SPAN_W-1:0];
            REG_LONG:        win_cfg.long_press_ms      = val[SPAN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_windows(input int idle, input int hold, input int settle,
                               input int very_long, input int long_ms);
        wait_results();
        write_reg(REG_IDLE_WINDOW, CFG_DATA_W'(idle));
        write_reg(REG_HOLD_NOTICE, CFG_DATA_W'(hold));
        write_reg(REG_SETTLE, CFG_DATA_W'(settle));
        write_reg(REG_VERY_LONG, CFG_DATA_W'(very_long));
        write_reg(REG_LONG, CFG_DATA_W'(long_ms));
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    function automatic longint pick_span();
        longint lim;
        lim = (win_cfg.long_press_ms < win_cfg.idle_window_ms) ? win_cfg.long_press_ms
                                                               : win_cfg.idle_window_ms;
        case ($urandom_range(0, 5))
            0, 1, 2: return $urandom_range(0, 32'(lim));
            3:       return near(win_cfg.long_press_ms);
            4:       return near(win_cfg.very_long_press_ms);
            default: return $urandom_range(0, win_cfg.very_long_press_ms +
                                              win_cfg.long_press_ms + 10);
        endcase
    endfunction

    // One burst of clicks with random spans and gaps, then settle probes.
    task automatic click_burst();
        int     clicks;
        int     i;
        longint press_at;
        longint rel_at;
        longint dur;
        longint nxt;
        longint lim;
        clicks = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 17);
        lim = (win_cfg.long_press_ms < win_cfg.idle_window_ms) ? win_cfg.long_press_ms
                                                               : win_cfg.idle_window_ms;
        for (i = 0; i < clicks; i++)
        begin
            press_at = clock_ms;
            emit(press_at, KEY_PRESS, 1'b1);
            dur = (i == clicks - 1) ? pick_span() : longint'($urandom_range(0, 32'(lim)));
            if (i == 0 && $urandom_range(0, 2) == 0)
                emit(press_at + near(win_cfg.hold_notice_ms), KEY_IDLE, 1'b1);
            rel_at = press_at + dur;
            if (rel_at < clock_ms)
                rel_at = clock_ms;
            emit(rel_at, KEY_RELEASE, 1'b1);
            if (i != clicks - 1)
            begin
                case ($urandom_range(0, 4))
                    0, 1, 2: nxt = press_at + $urandom_range(0, win_cfg.idle_window_ms);
                    3:       nxt = press_at + near(win_cfg.idle_window_ms);
                    default: nxt = rel_at + $urandom_range(0, 2 * win_cfg.idle_window_ms + 1);
                endcase
                if (nxt > clock_ms)
                    clock_ms = nxt;
            end
        end
        emit(rel_at + near(win_cfg.settle_ms), KEY_IDLE, 1'b1);
        if ($urandom_range(0, 1) == 0)
            emit(clock_ms + $urandom_range(0, win_cfg.settle_ms), KEY_IDLE, 1'b1);
        clock_ms = clock_ms + $urandom_range(0, 2 * win_cfg.idle_window_ms + 1);
    endtask

    task automatic noise_item();
        case ($urandom_range(0, 3))
            0:       send_item(NOW_W'($urandom() & NOW_MAX), KEY_W'($urandom_range(0, 3)),
                               1'b0);
            1:       send_item(NOW_W'(clock_ms), KEY_SPARE, 1'b1);
            2:       send_item(NOW_W'(clock_ms + $urandom_range(0, 2 * win_cfg.settle_ms)),
                               KEY_IDLE, 1'b1);
            default: send_item(NOW_W'($urandom() & NOW_MAX), KEY_W'($urandom_range(0, 3)),
                               1'b1);
        endcase
    endtask

    task automatic test_random_bursts(input int n);
        int start;
        start = live_items;
        while (live_items - start < n)
        begin
            if (clock_ms > TIME_REBASE)
                clock_ms = $urandom_range(0, 1 << 24);
            if ($urandom_range(0, 39) == 0)
                wait_results();
            if ($urandom_range(0, 9) == 0)
                noise_item();
            else
                click_burst();
        end
    endtask

    // Runs at the reset window settings, without any register write.
    task automatic test_directed_gestures();
        send_item(31'd1000, KEY_PRESS, 1'b1);
        send_item(31'd1100, KEY_RELEASE, 1'b1);
        send_item(31'd11101, KEY_IDLE, 1'b1);
        // Burst restart, hold notice just past its window, single after hold.
        send_item(31'd60000, KEY_PRESS, 1'b1);
        send_item(31'd90000, KEY_IDLE, 1'b1);
        send_item(31'd90001, KEY_IDLE, 1'b1);
        send_item(31'd100000, KEY_RELEASE, 1'b1);
        send_item(31'd110001, KEY_IDLE, 1'b1);
        // Triple with the spare key code and a gated-off release in the middle.
        send_item(31'd200000, KEY_PRESS, 1'b1);
        send_item(31'd200050, KEY_RELEASE, 1'b1);
        send_item(31'd200100, KEY_PRESS, 1'b1);
        send_item(31'd200150, KEY_RELEASE, 1'b1);
        send_item(31'd200200, KEY_PRESS, 1'b1);
        send_item(31'd200250, KEY_SPARE, 1'b1);
        send_item(31'd200300, KEY_RELEASE, 1'b0);
        send_item(31'd200300, KEY_RELEASE, 1'b1);
        send_item(31'd210301, KEY_IDLE, 1'b1);
        // Double at the top of the time range.
        send_item(31'h7fff0000, KEY_PRESS, 1'b1);
        send_item(31'h7fff0010, KEY_RELEASE, 1'b1);
        send_item(31'h7fff0020, KEY_PRESS, 1'b1);
        send_item(31'h7fff0030, KEY_RELEASE, 1'b1);
        send_item(31'h7fffffff, KEY_IDLE, 1'b1);
        // Time steps back for a press, leaving a huge span behind it.
        send_item(31'd5, KEY_PRESS, 1'b1);
        send_item(31'h7fffffff, KEY_IDLE, 1'b1);
        send_item(31'd1000000, KEY_PRESS, 1'b1);
        send_item(31'd1090001, KEY_RELEASE, 1'b1);
        send_item(31'd1100002, KEY_IDLE, 1'b1);
        clock_ms = 2000000;
    endtask

    task automatic test_default_windows();
        set_windows(IDLE_WINDOW_RST, HOLD_NOTICE_RST, SETTLE_RST, VERY_LONG_RST, LONG_RST);
        test_random_bursts(270);
    endtask

    task automatic test_zero_windows();
        set_windows(0, 0, 0, 0, 0);
        test_random_bursts(180);
    endtask

    task automatic test_max_windows();
        set_windows(1000000, 1000000, 1000000, 10000000, 10000000);
        test_random_bursts(220);
    endtask

    task automatic test_small_windows();
        set_windows($urandom_range(0, 300), $urandom_range(0, 300), $urandom_range(0, 300),
                    $urandom_range(0, 300), $urandom_range(0, 300));
        test_random_bursts(270);
    endtask

    task automatic test_random_windows();
        set_windows($urandom_range(0, 1000000), $urandom_range(0, 1000000),
                    $urandom_range(0, 1000000), $urandom_range(0, 10000000),
                    $urandom_range(0, 10000000));
        test_random_bursts(200);
    endtask

    // A quadruple or a five-plus burst stops the block; every later item is ignored.
    task automatic test_stop_after_burst();
        int     i;
        longint t;
        set_windows(IDLE_WINDOW_RST, HOLD_NOTICE_RST, SETTLE_RST, VERY_LONG_RST, LONG_RST);
        stop_allowed = 1'b1;
        stop_clicks  = ($urandom_range(0, 1) == 0) ? 4 : $urandom_range(5, 20);
        t = (clock_ms > longint'(gest.press_time)) ? clock_ms : longint'(gest.press_time);
        t = t + IDLE_WINDOW_RST + 1;
        for (i = 0; i < stop_clicks; i++)
        begin
            emit(t + 10 * i, KEY_PRESS, 1'b1);
            emit(t + 10 * i + 5, KEY_RELEASE, 1'b1);
        end
        emit(clock_ms + SETTLE_RST, KEY_IDLE, 1'b1);
        for (i = 0; i < 24; i++)
            send_item(NOW_W'($urandom() & NOW_MAX), KEY_W'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int k;
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        gest       = '0;
        win_cfg    = {IDLE_WINDOW_RST, HOLD_NOTICE_RST, SETTLE_RST, VERY_LONG_RST, LONG_RST};
        burst_left = 0;
        stall_left = 0;
        clock_ms   = 0;
        stop_allowed = 1'b0;
        settings_used = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_gestures();
        test_default_windows();
        test_zero_windows();
        test_max_windows();
        test_small_windows();
        test_random_windows();
        test_random_windows();
        test_random_windows();
        test_stop_after_burst();

        s_tvalid <= 1'b0;
        for (k = 0; k < 5000 && verdicts.size() != 0; k++)
            @(posedge clk);
        if (verdicts.size() != 0)
            report("results still missing at end, count", 0, verdicts.size());
        repeat (8) @(posedge clk);

        $display("covered %0d live and %0d ignored items, %0d results, %0d window settings, "
                 , live_items, ignored_items, results, settings_used,
                 "%0d diverted stops, final burst of %0d clicks", diverted, stop_clicks);
        $display("actions seen: none %0d hold %0d single %0d single-hold %0d double %0d ",
                 action_seen[0], action_seen[1], action_seen[2], action_seen[3],
                 action_seen[4], "triple %0d reboot %0d activate %0d very-long %0d long %0d",
                 action_seen[5], action_seen[6], action_seen[7], action_seen[8],
                 action_seen[9]);
        if (errors == 0)
            $display("multi_click_gesture_classifier regression: pass");
        else
            $display("multi_click_gesture_classifier regression: fail");
        $finish;
    end

endmodule

>>> files.f
src/mcg_pkg.sv
src/mcg_core.sv
src/multi_click_gesture_classifier.sv
tb/tb_multi_click_gesture_classifier.sv
